// File: rtl/twia_pkg.sv
package twia_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int TIME_BITS     = 16;
  localparam int IDX_W         = $clog2(MAX_INTERVALS);
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int UPC_W         = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD_KM1,
    OP_SHIFT,
    OP_PUT,
    OP_CLR_K,
    OP_RD_K,
    OP_ASSIGN,
    OP_EMIT,
    OP_EMIT_FAIL,
    OP_CLEAR
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_FULL,
    C_K_ZERO,
    C_RD_LE,
    C_NOT_LAST,
    C_K_EQ_CNT,
    C_K_LT_CNT,
    C_FAIL,
    C_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic full;
    logic k_zero;
    logic rd_le;
    logic not_last;
    logic k_eq_cnt;
    logic k_lt_cnt;
    logic fail;
    logic out_blocked;
  } flags_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [IDX_W-1:0]     origin;
  } entry_t;

  localparam logic [UPC_W-1:0] S_WAIT      = 4'd0;
  localparam logic [UPC_W-1:0] S_FULL_CHK  = 4'd1;
  localparam logic [UPC_W-1:0] S_INS_RD    = 4'd2;
  localparam logic [UPC_W-1:0] S_INS_CMP   = 4'd3;
  localparam logic [UPC_W-1:0] S_INS_MOVE  = 4'd4;
  localparam logic [UPC_W-1:0] S_INS_PUT   = 4'd5;
  localparam logic [UPC_W-1:0] S_LAST_CHK  = 4'd6;
  localparam logic [UPC_W-1:0] S_AS_RD     = 4'd7;
  localparam logic [UPC_W-1:0] S_AS_DO     = 4'd8;
  localparam logic [UPC_W-1:0] S_AS_LOOP   = 4'd9;
  localparam logic [UPC_W-1:0] S_OUT_SETUP = 4'd10;
  localparam logic [UPC_W-1:0] S_OUT_EMIT  = 4'd11;
  localparam logic [UPC_W-1:0] S_OUT_LOOP  = 4'd12;
  localparam logic [UPC_W-1:0] S_OUT_DONE  = 4'd13;
  localparam logic [UPC_W-1:0] S_FAIL_EMIT = 4'd14;
  localparam logic [UPC_W-1:0] S_FAIL_DONE = 4'd15;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    unique case (upc)
      S_WAIT:      w = '{OP_ACCEPT,    C_NO_IN,       S_WAIT};
      S_FULL_CHK:  w = '{OP_NONE,      C_FULL,        S_LAST_CHK};
      S_INS_RD:    w = '{OP_RD_KM1,    C_K_ZERO,      S_INS_PUT};
      S_INS_CMP:   w = '{OP_NONE,      C_RD_LE,       S_INS_PUT};
      S_INS_MOVE:  w = '{OP_SHIFT,     C_ALWAYS,      S_INS_RD};
      S_INS_PUT:   w = '{OP_PUT,       C_NEVER,       S_WAIT};
      S_LAST_CHK:  w = '{OP_CLR_K,     C_NOT_LAST,    S_WAIT};
      S_AS_RD:     w = '{OP_RD_K,      C_K_EQ_CNT,    S_OUT_SETUP};
      S_AS_DO:     w = '{OP_ASSIGN,    C_FAIL,        S_FAIL_EMIT};
      S_AS_LOOP:   w = '{OP_NONE,      C_ALWAYS,      S_AS_RD};
      S_OUT_SETUP: w = '{OP_CLR_K,     C_NEVER,       S_WAIT};
      S_OUT_EMIT:  w = '{OP_EMIT,      C_OUT_BLOCKED, S_OUT_EMIT};
      S_OUT_LOOP:  w = '{OP_NONE,      C_K_LT_CNT,    S_OUT_EMIT};
      S_OUT_DONE:  w = '{OP_CLEAR,     C_ALWAYS,      S_WAIT};
      S_FAIL_EMIT: w = '{OP_EMIT_FAIL, C_OUT_BLOCKED, S_FAIL_EMIT};
      S_FAIL_DONE: w = '{OP_CLEAR,     C_ALWAYS,      S_WAIT};
      default:     w = '{OP_NONE,      C_ALWAYS,      S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/two_worker_interval_assigner_unit.sv
// Load: each interval is inserted in sorted order, shifting stored entries up one place.
// Solve: stored intervals are assigned in sorted order, then results are emitted while the output is not stalled.
// Entries move through the sorted store one at a time: read (S_INS_RD), compare (S_INS_CMP), write (S_INS_MOVE).
// Results leave through a one-entry output register.
// Reset (async, active low) empties the set and frees both workers; store unset.
module two_worker_interval_assigner_unit
  import twia_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TIME_BITS-1:0] start_time_i,
  input  logic [TIME_BITS-1:0] end_time_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     interval_index_o,
  output logic                 worker_o,
  output logic                 impossible_o,
  output logic                 last_result_o
);

  op_e    op;
  flags_t flags;

  entry_t store_mem [MAX_INTERVALS];
  entry_t rd_q;
  logic   rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic   wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  logic [TIME_BITS-1:0] s_q, e_q;
  logic                 last_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     k_q, k_d;
  logic [TIME_BITS-1:0] busy0_q, busy0_d, busy1_q, busy1_d;
  logic [MAX_INTERVALS-1:0] asg_q;

  logic out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q;
  logic out_worker_q, out_imp_q, out_last_q;

  logic accept, out_free, fit0, fit1, emit, emit_fail;

  twia_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  assign accept    = (op == OP_ACCEPT) && in_valid_i;
  assign in_stall_o = (op != OP_ACCEPT);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fit0      = busy0_q <= rd_q.start_time;
  assign fit1      = busy1_q <= rd_q.start_time;
  assign emit      = (op == OP_EMIT) && out_free;
  assign emit_fail = (op == OP_EMIT_FAIL) && out_free;

  always_comb begin
    flags.no_in       = !in_valid_i;
    flags.full        = (cnt_q == CNT_W'(MAX_INTERVALS));
    flags.k_zero      = (k_q == '0);
    flags.rd_le       = (rd_q.start_time != s_q) ? (rd_q.start_time < s_q)
                                                 : (rd_q.end_time <= e_q);
    flags.not_last    = !last_q;
    flags.k_eq_cnt    = (k_q == cnt_q);
    flags.k_lt_cnt    = (k_q < cnt_q);
    flags.fail        = !fit0 && !fit1;
    flags.out_blocked = !out_free;
  end

  always_comb begin
    rd_en   = (op == OP_RD_KM1) || (op == OP_RD_K);
    rd_addr = (op == OP_RD_KM1) ? IDX_W'(k_q - CNT_W'(1)) : k_q[IDX_W-1:0];
    wr_en   = (op == OP_SHIFT) || (op == OP_PUT);
    wr_addr = k_q[IDX_W-1:0];
    wr_data = (op == OP_SHIFT) ? rd_q : entry_t'{s_q, e_q, cnt_q[IDX_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    k_d     = k_q;
    busy0_d = busy0_q;
    busy1_d = busy1_q;
    unique case (op)
      OP_ACCEPT: k_d = cnt_q;
      OP_SHIFT:  k_d = k_q - CNT_W'(1);
      OP_PUT:    cnt_d = cnt_q + CNT_W'(1);
      OP_CLR_K:  k_d = '0;
      OP_ASSIGN: begin
        k_d = k_q + CNT_W'(1);
        if (fit0) begin
          busy0_d = rd_q.end_time;
        end else if (fit1) begin
          busy1_d = rd_q.end_time;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          k_d = k_q + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_d   = '0;
        busy0_d = '0;
        busy1_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      k_q     <= '0;
      busy0_q <= '0;
      busy1_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      busy0_q <= busy0_d;
      busy1_q <= busy1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q    <= start_time_i;
      e_q    <= end_time_i;
      last_q <= last_i;
    end
    if ((op == OP_ASSIGN) && (fit0 || fit1)) begin
      asg_q[rd_q.origin] <= !fit0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit || emit_fail) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_idx_q    <= k_q[IDX_W-1:0];
      out_worker_q <= asg_q[k_q[IDX_W-1:0]];
      out_imp_q    <= 1'b0;
      out_last_q   <= (k_q + CNT_W'(1)) == cnt_q;
    end else if (emit_fail) begin
      out_idx_q    <= '0;
      out_worker_q <= 1'b0;
      out_imp_q    <= 1'b1;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign interval_index_o = out_idx_q;
  assign worker_o         = out_worker_q;
  assign impossible_o     = out_imp_q;
  assign last_result_o    = out_last_q;

endmodule

// File: rtl/twia_seq.sv
module twia_seq
  import twia_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output op_e    op_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            word;
  logic             taken;

  assign word = ucode(upc_q);
  assign op_o = word.op;

  always_comb begin
    unique case (word.cond)
      C_NEVER:       taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_IN:       taken = flags_i.no_in;
      C_FULL:        taken = flags_i.full;
      C_K_ZERO:      taken = flags_i.k_zero;
      C_RD_LE:       taken = flags_i.rd_le;
      C_NOT_LAST:    taken = flags_i.not_last;
      C_K_EQ_CNT:    taken = flags_i.k_eq_cnt;
      C_K_LT_CNT:    taken = flags_i.k_lt_cnt;
      C_FAIL:        taken = flags_i.fail;
      C_OUT_BLOCKED: taken = flags_i.out_blocked;
      default:       taken = 1'b0;
    endcase
  end

  assign upc_d = taken ? word.target : upc_q + UPC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule
